// File: rtl/rau_pkg.sv
// Package for the rational arithmetic unit: word types, mode/status codes,
// command and status structs shared by controller and datapath. No dependencies.
package rau_pkg;
  localparam int unsigned WordBitsDef = 64;

  localparam logic [2:0] ModeNorm = 3'd0;
  localparam logic [2:0] ModeAdd  = 3'd1;
  localparam logic [2:0] ModeSub  = 3'd2;
  localparam logic [2:0] ModeMul  = 3'd3;
  localparam logic [2:0] ModeDiv  = 3'd4;
  localparam logic [2:0] ModeCmp  = 3'd5;

  localparam logic [1:0] StatOk   = 2'd0;
  localparam logic [1:0] StatZero = 2'd1;
  localparam logic [1:0] StatOvf  = 2'd2;

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] a_num;
    logic [63:0] a_den;
    logic [63:0] b_num;
    logic [63:0] b_den;
  } in_word_t;

  typedef struct packed {
    logic [63:0] res_num;
    logic [62:0] res_den;
    logic [1:0]  order;
    logic [1:0]  status;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture input word, decode
    logic mul;      // run one multiplier step
    logic form;     // form N and D from products
    logic gcd;      // run one gcd step
    logic div;      // run one division step
    logic finish;   // build result word
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic early;    // result known after decode (error, bad mode)
    logic mul_done;
    logic gcd_done;
    logic div_done;
  } dp_stat_t;
endpackage

// File: rtl/rau_ctrl.sv
// Controller state machine of the rational arithmetic unit.
// Depends on rau_pkg for the command and status structs.
module rau_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_go_i,
  input  logic              out_hold_i,
  output logic              busy_o,
  output logic              done_o,
  output rau_pkg::dp_cmd_t  cmd_o,
  input  rau_pkg::dp_stat_t stat_i
);
  import rau_pkg::*;

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SDec  = 3'd1;
  localparam logic [2:0] SMul  = 3'd2;
  localparam logic [2:0] SForm = 3'd3;
  localparam logic [2:0] SGcd  = 3'd4;
  localparam logic [2:0] SDiv  = 3'd5;
  localparam logic [2:0] SFin  = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    done_o  = 1'b0;
    case (state_q)
      SIdle: begin
        if (in_go_i) begin
          cmd_o.load = 1'b1;
          state_d    = SDec;
        end
      end
      SDec: begin
        if (stat_i.early) state_d = SFin;
        else state_d = SMul;
      end
      SMul: begin
        cmd_o.mul = 1'b1;
        if (stat_i.mul_done) state_d = SForm;
      end
      SForm: begin
        cmd_o.form = 1'b1;
        state_d    = SGcd;
      end
      SGcd: begin
        cmd_o.gcd = 1'b1;
        if (stat_i.gcd_done) state_d = SDiv;
      end
      SDiv: begin
        cmd_o.div = 1'b1;
        if (stat_i.div_done) state_d = SFin;
      end
      SFin: begin
        // hold while the previous result still waits
        if (!out_hold_i) begin
          cmd_o.finish = 1'b1;
          done_o       = 1'b1;
          state_d      = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  assign busy_o = (state_q != SIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

// File: rtl/rau_dp.sv
// Datapath of the rational arithmetic unit: operand decode, shift-add
// multiplier, binary gcd, restoring divider. Depends on rau_pkg.
module rau_dp #(
  parameter int unsigned WordBits = rau_pkg::WordBitsDef
) (
  input  logic               clk_i,
  input  rau_pkg::in_word_t  in_i,
  input  rau_pkg::dp_cmd_t   cmd_i,
  output rau_pkg::dp_stat_t  stat_o,
  output rau_pkg::out_word_t res_o
);
  import rau_pkg::*;

  localparam int unsigned W  = WordBits;
  localparam int unsigned W2 = 2 * WordBits;
  localparam int unsigned CntBits = $clog2(W2 + 1);
  localparam int unsigned KBits   = $clog2(W2 + 1);

  logic [W-1:0]  an_q, ad_q, bn_q, bd_q;
  logic          ans_q, ads_q, bns_q, bds_q;
  logic [2:0]    mode_q;
  logic          early_q;
  logic [1:0]    estat_q;

  // magnitude helper
  function automatic logic [W-1:0] mag_f(input logic [W-1:0] v);
    return v[W-1] ? (~v + {{(W-1){1'b0}}, 1'b1}) : v;
  endfunction

  // three products, computed one multiplier bit per cycle in parallel
  logic [W2-1:0] p1_q, p2_q, p3_q;   // an*bd (or an*bn), bn*ad, ad*bd (or ad*bn)
  logic [W-1:0]  m1_q, m2_q, m3_q;   // multiplier shift registers
  logic [W2-1:0] c1_q, c2_q, c3_q;   // shifted multiplicands
  logic [CntBits-1:0] cnt_q;

  logic [W2-1:0] n_q, d_q;   // numerator and denominator to reduce
  logic          neg_q;
  logic [W2-1:0] ga_q, gb_q; // gcd operands
  logic [KBits-1:0] k_q;
  logic [1:0]    gph_q;      // 0 common twos, 1 strip a, 2 loop, 3 shift back
  logic          gdone_q;
  logic [W2-1:0] g_q;
  logic [W2-1:0] qn_q, rn_q, qd_q, rd_q;
  logic [CntBits-1:0] dcnt_q;
  logic [W2-1:0] nsh_q, dsh_q;
  out_word_t     res_q, res_d;

  // decode combinational
  logic [W-1:0] in_an, in_ad, in_bn, in_bd;
  assign in_an = in_i.a_num[W-1:0];
  assign in_ad = in_i.a_den[W-1:0];
  assign in_bn = in_i.b_num[W-1:0];
  assign in_bd = in_i.b_den[W-1:0];

  logic ad_zero, bd_zero, bn_zero, bad_mode, is_err;
  assign ad_zero  = (in_ad == '0);
  assign bd_zero  = (in_bd == '0);
  assign bn_zero  = (in_bn == '0);
  assign bad_mode = (in_i.mode > ModeCmp);
  assign is_err   = ad_zero || ((in_i.mode != ModeNorm) && bd_zero)
                 || ((in_i.mode == ModeDiv) && bn_zero);

  // multiplier operand selection
  logic [W-1:0] x1, y1, x2, y2, x3, y3;
  always_comb begin
    x1 = mag_f(in_an); y1 = mag_f(in_bd);
    x2 = mag_f(in_bn); y2 = mag_f(in_ad);
    x3 = mag_f(in_ad); y3 = mag_f(in_bd);
    case (in_i.mode)
      ModeMul: begin
        y1 = mag_f(in_bn);
      end
      ModeDiv: begin
        y3 = mag_f(in_bn);
      end
      default: ;
    endcase
  end

  // gcd step logic
  logic [W2-1:0] gbs, gmin, gmax;
  assign gbs  = gb_q[0] ? gb_q : (gb_q >> 1);
  assign gmin = (ga_q > gbs) ? gbs : ga_q;
  assign gmax = (ga_q > gbs) ? ga_q : gbs;

  // divider step
  logic [W2-1:0] rn_sh, rd_sh;
  logic          rn_ge, rd_ge;
  assign rn_sh = {rn_q[W2-2:0], nsh_q[W2-1]};
  assign rd_sh = {rd_q[W2-2:0], dsh_q[W2-1]};
  assign rn_ge = rn_sh >= g_q;
  assign rd_ge = rd_sh >= g_q;

  // compare and sum on products
  logic s1, s2, ln, rn, p_ge;
  logic [1:0] ord;
  assign p_ge = (p1_q >= p2_q);
  always_comb begin
    s1 = ans_q ^ ads_q;
    s2 = (bns_q ^ bds_q) ^ (mode_q == ModeSub);
    ln = s1 && (an_q != '0);
    rn = (bns_q ^ bds_q) && (bn_q != '0);
    if (ln != rn) ord = ln ? 2'd0 : 2'd2;
    else if (p1_q == p2_q) ord = 2'd1;
    else ord = ((p1_q > p2_q) ^ ln) ? 2'd2 : 2'd0;
  end

  localparam logic [W2-1:0] Lim  = {{(W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [W2-1:0] SBit = {{W{1'b0}}, 1'b1, {(W-1){1'b0}}};

  logic [W-1:0] nlo;
  logic         nz, ovf;
  assign nlo = qn_q[W-1:0];
  assign nz  = (qn_q == '0);
  assign ovf = (qd_q > Lim) || !((qn_q <= Lim) || (neg_q && !nz && qn_q == SBit));

  always_comb begin
    res_d = '0;
    if (early_q) begin
      res_d.status = estat_q;
    end else if (mode_q == ModeCmp) begin
      res_d.order = ord;
    end else if (ovf) begin
      res_d.status = StatOvf;
    end else begin
      res_d.res_num = 64'(signed'((neg_q && !nz) ? (~nlo + 1'b1) : nlo));
      res_d.res_den = 63'(qd_q[W-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= in_i.mode;
      an_q    <= mag_f(in_an); ans_q <= in_an[W-1];
      ad_q    <= mag_f(in_ad); ads_q <= in_ad[W-1];
      bn_q    <= mag_f(in_bn); bns_q <= in_bn[W-1];
      bd_q    <= mag_f(in_bd); bds_q <= in_bd[W-1];
      early_q <= bad_mode || is_err;
      estat_q <= bad_mode ? StatOk : (is_err ? StatZero : StatOk);
      m1_q <= y1; m2_q <= y2; m3_q <= y3;
      c1_q <= {{W{1'b0}}, x1}; c2_q <= {{W{1'b0}}, x2}; c3_q <= {{W{1'b0}}, x3};
      p1_q <= '0; p2_q <= '0; p3_q <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.mul) begin
      if (m1_q[0]) p1_q <= p1_q + c1_q;
      if (m2_q[0]) p2_q <= p2_q + c2_q;
      if (m3_q[0]) p3_q <= p3_q + c3_q;
      m1_q <= m1_q >> 1; m2_q <= m2_q >> 1; m3_q <= m3_q >> 1;
      c1_q <= c1_q << 1; c2_q <= c2_q << 1; c3_q <= c3_q << 1;
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.form) begin
      case (mode_q)
        ModeNorm: begin
          n_q <= {{W{1'b0}}, an_q}; d_q <= {{W{1'b0}}, ad_q};
          ga_q <= {{W{1'b0}}, an_q}; gb_q <= {{W{1'b0}}, ad_q};
          neg_q <= ans_q ^ ads_q;
        end
        ModeMul, ModeDiv: begin
          n_q <= p1_q; d_q <= p3_q; ga_q <= p1_q; gb_q <= p3_q;
          neg_q <= ans_q ^ ads_q ^ bns_q ^ bds_q;
        end
        default: begin
          d_q <= p3_q; gb_q <= p3_q;
          if (s1 == s2) begin
            n_q <= p1_q + p2_q; ga_q <= p1_q + p2_q; neg_q <= s1;
          end else if (p_ge) begin
            n_q <= p1_q - p2_q; ga_q <= p1_q - p2_q; neg_q <= s1;
          end else begin
            n_q <= p2_q - p1_q; ga_q <= p2_q - p1_q; neg_q <= s2;
          end
        end
      endcase
      k_q <= '0; gph_q <= 2'd0; gdone_q <= 1'b0;
    end
    if (cmd_i.gcd && !gdone_q) begin
      if (ga_q == '0) begin
        g_q <= gb_q; gdone_q <= 1'b1;
      end else if (gb_q == '0 && gph_q == 2'd0) begin
        g_q <= ga_q; gdone_q <= 1'b1;
      end else begin
        case (gph_q)
          2'd0: begin
            if (!ga_q[0] && !gb_q[0]) begin
              ga_q <= ga_q >> 1; gb_q <= gb_q >> 1; k_q <= k_q + 1'b1;
            end else gph_q <= 2'd1;
          end
          2'd1: begin
            if (!ga_q[0]) ga_q <= ga_q >> 1;
            else gph_q <= 2'd2;
          end
          2'd2: begin
            // strip one two from b, then swap and subtract when odd
            if (gb_q == '0) gph_q <= 2'd3;
            else if (!gb_q[0]) gb_q <= gb_q >> 1;
            else begin
              ga_q <= gmin; gb_q <= gmax - gmin;
            end
          end
          default: begin
            if (k_q != '0) begin
              ga_q <= ga_q << 1; k_q <= k_q - 1'b1;
            end else begin
              g_q <= ga_q; gdone_q <= 1'b1;
            end
          end
        endcase
      end
      qn_q <= '0; qd_q <= '0; rn_q <= '0; rd_q <= '0;
      nsh_q <= n_q; dsh_q <= d_q; dcnt_q <= '0;
    end
    if (cmd_i.div) begin
      rn_q <= rn_ge ? rn_sh - g_q : rn_sh;
      rd_q <= rd_ge ? rd_sh - g_q : rd_sh;
      qn_q <= {qn_q[W2-2:0], rn_ge};
      qd_q <= {qd_q[W2-2:0], rd_ge};
      nsh_q <= nsh_q << 1; dsh_q <= dsh_q << 1;
      dcnt_q <= dcnt_q + 1'b1;
    end
    if (cmd_i.finish) begin
      res_q <= res_d;
    end
  end

  assign stat_o.early    = early_q;
  assign stat_o.mul_done = (cnt_q == CntBits'(W - 1)) && cmd_i.mul;
  assign stat_o.gcd_done = gdone_q;
  assign stat_o.div_done = (dcnt_q == CntBits'(W2 - 1)) && cmd_i.div;
  assign res_o = res_q;
endmodule

// File: rtl/rational_arithmetic_unit.sv
// Rational arithmetic unit top level: handshake, output register, controller
// and datapath instances. Depends on rau_pkg, rau_ctrl and rau_dp.
//
// Usage: an input word (mode and two signed fraction pairs) is taken on
// in_valid_i with in_stall_o low. The unit works one word at a time; each
// word gives exactly one result word on out_valid_o, held until a cycle
// with out_stall_i low. A word runs through the multiplier (shift-add, three
// products side by side), the binary gcd (one shift or one subtract a
// cycle), and the restoring divider for both quotients, then the finish
// step. Error and unused modes skip the multiplier, gcd and divider and go
// from decode straight to the finish step; compare runs the full sequence.
// The next word is accepted once the controller is idle, even while a result
// waits in the output register; a new result is not finished until the
// output register is free. Reset clears the controller and the output valid
// flag; no results are pending after reset. A stalled result holds its
// value.
module rational_arithmetic_unit #(
  parameter int unsigned WordBits = rau_pkg::WordBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rau_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rau_pkg::out_word_t out_data_o
);
  import rau_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     busy, done, go, out_valid_q, hold;
  out_word_t res;

  // hold the finish step while the previous result is still waiting
  assign hold = out_valid_q && out_stall_i;
  assign in_stall_o = busy;
  assign go = in_valid_i && !busy;

  // controller stays in finish while held
  rau_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_go_i   (go),
    .out_hold_i(hold),
    .busy_o    (busy),
    .done_o    (done),
    .cmd_o     (cmd),
    .stat_i    (stat)
  );

  rau_dp #(.WordBits(WordBits)) u_dp (
    .clk_i  (clk_i),
    .in_i   (in_data_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .res_o  (res)
  );

  logic fin_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      fin_q       <= 1'b0;
    end else begin
      fin_q <= done;
      if (fin_q) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res;

  property p_no_accept_busy;
    @(posedge clk_i) disable iff (!rst_ni) busy |-> !go;
  endproperty
  assert property (p_no_accept_busy) else $error("word accepted while busy");

  property p_stall_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && out_stall_i && !fin_q) |=> $stable(out_data_o);
  endproperty
  assert property (p_stall_hold) else $error("result changed under stall");
endmodule
